// ===== rtl/pixel_to_arm_homography_macros.svh =====
// ----------------------------------------------------------------------------
// pixel_to_arm_homography_macros.svh
// Assertion macros used by the checker file pth_checker.sv.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_ARM_HOMOGRAPHY_MACROS_SVH
`define PIXEL_TO_ARM_HOMOGRAPHY_MACROS_SVH

// Checked outside reset only.
`define PTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_pkg
// Types and constants of the pixel-to-arm homography mapper.
// ----------------------------------------------------------------------------
package pth_pkg;

  localparam int NUM_COEF     = 8;
  localparam int COEF_W       = 48;
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int SIDE_Y_MIN   = 50;
  localparam int SIDE_X_MAX   = 640;
  localparam int Z_SLOPE_Q16  = 36906;
  localparam int Z_OFFSET_Q16 = 18260425;
  localparam int Z_TOP_ONLY   = 280;
  localparam int DEN_MIN_LSB  = 4;
  localparam int QBITS        = 17;   // quotient bits resolved by the divider

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  // register indexes
  localparam logic [2:0] REG_H00 = 3'd0;
  localparam logic [2:0] REG_H01 = 3'd1;
  localparam logic [2:0] REG_H02 = 3'd2;
  localparam logic [2:0] REG_H10 = 3'd3;
  localparam logic [2:0] REG_H11 = 3'd4;
  localparam logic [2:0] REG_H12 = 3'd5;
  localparam logic [2:0] REG_H20 = 3'd6;
  localparam logic [2:0] REG_H21 = 3'd7;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [7:0] CLASS_MAX = 8'd2;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_set_t;

  // item handed from the front to the divider side
  typedef struct packed {
    logic        ok;
    logic [1:0]  kind;
    logic [15:0] z;
    logic        neg_x;
    logic        neg_y;
    logic [63:0] num_x;   // 2*|nx| + |den|
    logic [63:0] num_y;   // 2*|ny| + |den|
    logic [63:0] den2;    // 2*|den|
  } front_item_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  kind;
    logic [15:0] z;
    logic        neg_x;
    logic        neg_y;
    logic [63:0] den2;
  } back_meta_t;

endpackage

// ===== rtl/pth_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_front
// Checks a detection, computes z and the homography sums, prepares the
// operands of the rounding division. Five stages, one shared enable.
// ----------------------------------------------------------------------------
module pth_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          class_code,
  input  logic signed [15:0]  top_px_x,
  input  logic signed [15:0]  top_px_y,
  input  logic signed [15:0]  side_px_x,
  input  logic signed [15:0]  side_px_y,
  input  pth_pkg::coef_set_t  coef,
  output logic                out_valid,
  input  logic                out_ready,
  output pth_pkg::front_item_t out_item
);
  import pth_pkg::*;

  logic en;
  logic v1, v2, v3, v4, v5;

  // stage 1
  logic        ok1;
  logic [1:0]  kind1;
  logic [15:0] z1;
  logic signed [15:0] u1, w1;
  // stage 2
  logic        ok2;
  logic [1:0]  kind2;
  logic [15:0] z2;
  logic signed [63:0] p0, p1, p3, p4, p6, p7;
  // stage 3
  logic        ok3;
  logic [1:0]  kind3;
  logic [15:0] z3;
  logic signed [63:0] nx3, ny3, den3;
  // stage 4
  logic        ok4;
  logic [1:0]  kind4;
  logic [15:0] z4;
  logic        negx4, negy4;
  logic [63:0] mx4, my4, md4;

  logic side_absent, top_in, side_in, cls_in;
  logic signed [32:0] zprod;
  logic [31:0] zsum;

  assign en       = !v5 || out_ready;
  assign in_ready = en;

  always_comb begin
    side_absent = (side_px_x == 16'sd0) && (side_px_y == 16'sd0);
    top_in   = (top_px_x >= 0) && (top_px_x < FRAME_WIDTH) &&
               (top_px_y >= 0) && (top_px_y < FRAME_HEIGHT);
    side_in  = side_absent || ((side_px_y >= SIDE_Y_MIN) && (side_px_x >= 0) &&
               (side_px_x <= SIDE_X_MAX));
    cls_in   = class_code <= CLASS_MAX;
    zprod    = 33'(side_px_x) * 33'(Z_SLOPE_Q16);
    zsum     = zprod[31:0] + 32'(Z_OFFSET_Q16 + 32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1   <= top_in && side_in && cls_in;
      kind1 <= 2'(class_code + 8'd1);
      z1    <= side_absent ? 16'(Z_TOP_ONLY) : zsum[31:16];
      u1    <= top_px_x;
      w1    <= top_px_y;

      ok2 <= ok1; kind2 <= kind1; z2 <= z1;
      p0  <= 64'($signed(coef[REG_H00])) * 64'(u1);
      p1  <= 64'($signed(coef[REG_H01])) * 64'(w1);
      p3  <= 64'($signed(coef[REG_H10])) * 64'(u1);
      p4  <= 64'($signed(coef[REG_H11])) * 64'(w1);
      p6  <= 64'($signed(coef[REG_H20])) * 64'(u1);
      p7  <= 64'($signed(coef[REG_H21])) * 64'(w1);

      ok3  <= ok2; kind3 <= kind2; z3 <= z2;
      nx3  <= p0 + p1 + 64'($signed(coef[REG_H02]));
      ny3  <= p3 + p4 + 64'($signed(coef[REG_H12]));
      den3 <= p6 + p7 + $signed(ONE_Q32);

      ok4   <= ok3; kind4 <= kind3; z4 <= z3;
      negx4 <= nx3[63] ^ den3[63];
      negy4 <= ny3[63] ^ den3[63];
      mx4   <= nx3[63] ? 64'(-nx3) : 64'(nx3);
      my4   <= ny3[63] ? 64'(-ny3) : 64'(ny3);
      md4   <= den3[63] ? 64'(-den3) : 64'(den3);

      out_item.ok    <= ok4 && (md4 > 64'(DEN_MIN_LSB));
      out_item.kind  <= kind4;
      out_item.z     <= z4;
      out_item.neg_x <= negx4;
      out_item.neg_y <= negy4;
      out_item.num_x <= {mx4[62:0], 1'b0} + md4;
      out_item.num_y <= {my4[62:0], 1'b0} + md4;
      out_item.den2  <= {md4[62:0], 1'b0};
    end
  end

  assign out_valid = v5;

endmodule

// ===== rtl/pth_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_queue
// Four-entry queue between the front pipeline and the divider.
// ----------------------------------------------------------------------------
module pth_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  pth_pkg::front_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output pth_pkg::front_item_t pop_item
);
  import pth_pkg::*;

  front_item_t slots [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic        do_push, do_pop;

  assign push_ready = count != 3'd4;
  assign pop_valid  = count != 3'd0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== rtl/pth_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_back
// Pipelined restoring divider, one quotient bit per stage for x and y,
// then sign, saturation and the output register.
// ----------------------------------------------------------------------------
module pth_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pth_pkg::front_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 ok,
  output logic [1:0]           target_kind,
  output logic signed [15:0]   arm_x_mm,
  output logic signed [15:0]   arm_y_mm,
  output logic signed [15:0]   arm_z_mm
);
  import pth_pkg::*;

  localparam int WX = 64 + QBITS;

  logic             en;
  logic             sv    [QBITS+1];
  back_meta_t       meta  [QBITS+1];
  logic [63:0]      rem_x [QBITS+1];
  logic [63:0]      rem_y [QBITS+1];
  logic [QBITS-1:0] q_x   [QBITS+1];
  logic [QBITS-1:0] q_y   [QBITS+1];
  logic             ovf_x [QBITS+1];
  logic             ovf_y [QBITS+1];

  logic [QBITS-1:0] qx, qy;
  logic [15:0]      rx, ry;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: quotient overflow check
  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[0].ok    <= in_item.ok;
      meta[0].kind  <= in_item.kind;
      meta[0].z     <= in_item.z;
      meta[0].neg_x <= in_item.neg_x;
      meta[0].neg_y <= in_item.neg_y;
      meta[0].den2  <= in_item.den2;
      rem_x[0] <= in_item.num_x;
      rem_y[0] <= in_item.num_y;
      q_x[0]   <= '0;
      q_y[0]   <= '0;
      ovf_x[0] <= WX'(in_item.num_x) >= {in_item.den2, QBITS'(0)};
      ovf_y[0] <= WX'(in_item.num_y) >= {in_item.den2, QBITS'(0)};
    end
  end

  for (genvar i = 1; i <= QBITS; i++) begin : g_div
    localparam int K = QBITS - i;
    logic [WX-1:0] dsh;
    logic          tx, ty;
    logic [WX-1:0] dx, dy;

    assign dsh = WX'(meta[i-1].den2) << K;
    assign tx  = WX'(rem_x[i-1]) >= dsh;
    assign ty  = WX'(rem_y[i-1]) >= dsh;
    assign dx  = WX'(rem_x[i-1]) - dsh;
    assign dy  = WX'(rem_y[i-1]) - dsh;

    always_ff @(posedge clk) begin
      if (rst) sv[i] <= 1'b0;
      else if (en) sv[i] <= sv[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta[i]  <= meta[i-1];
        ovf_x[i] <= ovf_x[i-1];
        ovf_y[i] <= ovf_y[i-1];
        rem_x[i] <= tx ? dx[63:0] : rem_x[i-1];
        rem_y[i] <= ty ? dy[63:0] : rem_y[i-1];
        q_x[i]   <= q_x[i-1] | (QBITS'(tx) << K);
        q_y[i]   <= q_y[i-1] | (QBITS'(ty) << K);
      end
    end
  end

  assign qx = q_x[QBITS];
  assign qy = q_y[QBITS];

  always_comb begin
    if (meta[QBITS].neg_x) begin
      rx = (ovf_x[QBITS] || qx > QBITS'(32768)) ? 16'h8000 : 16'(-qx);
    end else begin
      rx = (ovf_x[QBITS] || qx > QBITS'(32767)) ? 16'h7FFF : qx[15:0];
    end
    if (meta[QBITS].neg_y) begin
      ry = (ovf_y[QBITS] || qy > QBITS'(32768)) ? 16'h8000 : 16'(-qy);
    end else begin
      ry = (ovf_y[QBITS] || qy > QBITS'(32767)) ? 16'h7FFF : qy[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok          <= meta[QBITS].ok;
      target_kind <= meta[QBITS].ok ? meta[QBITS].kind : KIND_NONE;
      arm_x_mm    <= meta[QBITS].ok ? rx : 16'sd0;
      arm_y_mm    <= meta[QBITS].ok ? ry : 16'sd0;
      arm_z_mm    <= meta[QBITS].ok ? meta[QBITS].z : 16'sd0;
    end
  end

endmodule

// ===== rtl/pixel_to_arm_homography.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_arm_homography
// Maps a top-camera detection to arm coordinates via a 3x3 homography.
// ----------------------------------------------------------------------------
//  channel   direction  sideband                     payload
//  s_axis    in         tuser: class_code[7:0]       tdata: top x, top y,
//                                                    side x, side y
//  m_axis    out        tuser: ok, target_kind       tdata: arm x, y, z
//  cfg       in         cfg_we, cfg_index            cfg_data (Q16.32)
//
//  Throughput is one transfer per cycle on each side unless a side stalls;
//  the path is 5 front stages, queue, overflow stage, 17 divider stages and
//  output reg. The divider is a bit-per-stage restoring divider.
//  rst is synchronous and restores the coefficients to their defaults.
//  The front and the divider stall separately; the 4-entry queue between
//  them absorbs the difference, and s_tready drops only when it is full.
// ----------------------------------------------------------------------------
module pixel_to_arm_homography (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tuser,    // [7:0] class_code
  input  logic [63:0] s_tdata,    // top_px_x, top_px_y, side_px_x, side_px_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,    // [0] ok, [2:1] target_kind
  output logic [47:0] m_tdata,    // arm_x_mm, arm_y_mm, arm_z_mm
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import pth_pkg::*;

  coef_set_t   coef;
  front_item_t f_item, q_item;
  logic        f_valid, f_ready, q_valid, q_ready;
  logic        ok;
  logic [1:0]  target_kind;
  logic signed [15:0] arm_x_mm, arm_y_mm, arm_z_mm;

  // Coefficient registers, reset to the calibrated homography.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[REG_H00] <= 48'sd166034846;
      coef[REG_H01] <= 48'sd1660477306;
      coef[REG_H02] <= 48'sd234100190356;
      coef[REG_H10] <= 48'sd2356231943;
      coef[REG_H11] <= -48'sd193595651;
      coef[REG_H12] <= 48'sd267454786117;
      coef[REG_H20] <= 48'sd1644972;
      coef[REG_H21] <= -48'sd455267;
    end else if (cfg_we) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // Front: range checks, z, products and divider operands.
  pth_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .class_code (s_tuser),
    .top_px_x   (s_tdata[15:0]),
    .top_px_y   (s_tdata[31:16]),
    .side_px_x  (s_tdata[47:32]),
    .side_px_y  (s_tdata[63:48]),
    .coef       (coef),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_item   (f_item)
  );

  pth_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back: rounding division, saturation, output register.
  pth_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_item     (q_item),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .ok          (ok),
    .target_kind (target_kind),
    .arm_x_mm    (arm_x_mm),
    .arm_y_mm    (arm_y_mm),
    .arm_z_mm    (arm_z_mm)
  );

  assign m_tuser = {target_kind, ok};
  assign m_tdata = {arm_z_mm, arm_y_mm, arm_x_mm};

endmodule

// ===== rtl/pth_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_checker
// Port-level checks on the result stream of the homography mapper.
// ----------------------------------------------------------------------------
`include "pixel_to_arm_homography_macros.svh"

module pth_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [2:0]  m_tuser,
  input logic [47:0] m_tdata
);

  `PTH_ASSERT_ALWAYS(a_rst_clears, rst |=> !m_tvalid, "m_tvalid after reset")
  `PTH_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
  `PTH_ASSERT(a_reject_zero, m_tvalid && !m_tuser[0] |-> m_tuser == 3'd0 && m_tdata == 48'd0, "reject not zeroed")
  `PTH_ASSERT(a_ok_kind, m_tvalid && m_tuser[0] |-> m_tuser[2:1] != 2'd0, "ok without kind")

endmodule

bind pixel_to_arm_homography pth_checker u_pth_checker (.*);
